FILE: src/rpn_stack_evaluator_top_macros.svh
// Assertion macros shared by the calculator RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef RPN_STACK_EVALUATOR_TOP_MACROS_SVH
`define RPN_STACK_EVALUATOR_TOP_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define RPN_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define RPN_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/rpn_pkg.sv
// Package for the RPN stack calculator: request codes, widths and defaults.
// No dependencies.
`timescale 1ns / 1ps
package rpn_pkg;
    localparam int DEFAULT_STACK_DEPTH = 128;
    localparam int DATA_W = 32;
    localparam int DEPTH_OUT_W = 8;

    typedef enum logic [2:0] {
        REQ_PUSH  = 3'd0,
        REQ_ADD   = 3'd1,
        REQ_SUB   = 3'd2,
        REQ_MUL   = 3'd3,
        REQ_DIV   = 3'd4,
        REQ_PRINT = 3'd5,
        REQ_UNK   = 3'd6,
        REQ_UNK7  = 3'd7
    } req_t;

    // Saturate a 48-bit signed value to Q16.16.
    function automatic logic [31:0] sat48(input logic signed [47:0] v);
        logic signed [47:0] hi;
        logic signed [47:0] lo;
        hi = 48'sd2147483647;
        lo = -48'sd2147483648;
        if (v > hi) return 32'h7fff_ffff;
        if (v < lo) return 32'h8000_0000;
        return v[31:0];
    endfunction
endpackage

FILE: src/rpn_divider.sv
// Iterative unsigned restoring divider: 48-bit dividend by 32-bit divisor.
// One quotient bit per cycle; depends on nothing outside this file.
`timescale 1ns / 1ps
module rpn_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [47:0] quotient
);
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [32:0] rem_reg;
    logic [47:0] quo_reg;
    logic [31:0] dvs_reg;
    logic [32:0] shifted;
    logic [33:0] diff;

    assign shifted = {rem_reg[31:0], quo_reg[47]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};

    // Control: count 48 steps, flag completion.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd47)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift a dividend bit in, subtract when it fits.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[33])
            begin
                rem_reg <= diff[32:0];
                quo_reg <= {quo_reg[46:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[46:0], 1'b0};
            end
        end
    end

    assign quotient = quo_reg;
endmodule

FILE: src/rpn_stack_evaluator_top.sv
// Top level of the RPN stack calculator: stack memory, sequencer, arithmetic.
// Depends on rpn_pkg, rpn_divider and rpn_stack_evaluator_top_macros.svh.
//
// One item is handled at a time. A push or unknown request goes straight to
// the result; print and a divide by a zero divisor pop one operand first; add,
// subtract, multiply and divide pop two (through the registered read port of
// the stack memory); multiply adds a registered product and divide waits on
// the 48-step bit-serial divider. The result sits in an output register; the
// next item is taken when idle and the result register is free or being drained.
`timescale 1ns / 1ps
module rpn_stack_evaluator_top #(
    parameter int STACK_DEPTH = rpn_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [2:0] req_type, [34:3] operand_value, zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [31:0] print_value, [32] print_valid,
                                   // [33] underflow_flag, [34] overflow_flag,
                                   // [35] divide_by_zero, [36] unknown_request,
                                   // [44:37] stack_depth, zero fill
);
    import rpn_pkg::*;
`include "rpn_stack_evaluator_top_macros.svh"

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_RDB, ST_GOTA, ST_MUL, ST_DIVW, ST_DIVF, ST_DONE
    } state_t;

    state_t         state_reg;
    logic [SPW-1:0] sp_reg;
    logic [2:0]     req_reg;
    logic [31:0]    b_reg;
    logic [31:0]    res_reg;
    logic           under_reg;
    logic           over_reg;
    logic           dz_reg;
    logic [63:0]    prod_reg;
    logic           neg_reg;

    // Tracks whether the pending pop found the stack empty.
    logic under_pending;
    logic under_pending_reg;
    assign under_pending = under_pending_reg;

    // Stack memory with registered read.
    logic [31:0]    stack_mem [STACK_DEPTH];
    logic [31:0]    rd_data;
    logic           we;
    logic [AW-1:0]  waddr;
    logic [31:0]    wdata;
    logic [AW-1:0]  raddr;

    always_ff @(posedge clk)
    begin
        if (we)
            stack_mem[waddr] <= wdata;
        rd_data <= stack_mem[raddr];
    end

    // Divider.
    logic        div_start;
    logic        div_done;
    logic [47:0] div_q;
    logic [31:0] a_mag;
    logic [31:0] b_mag;
    logic [31:0] a_val;

    rpn_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({a_mag, 16'h0000}),
        .divisor  (b_mag),
        .done     (div_done),
        .quotient (div_q)
    );

    logic           out_free;
    logic           accept;
    logic           sp_nz;
    logic [31:0]    popped;
    logic [32:0]    sum;
    logic [32:0]    dif;
    logic [63:0]    umul;
    logic [47:0]    mag48;
    logic [48:0]    sgn49;
    logic           do_push;
    logic [SPW-1:0] sp_after;

    assign out_free = !m_tvalid || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign sp_nz    = (sp_reg != '0);
    assign raddr    = AW'(sp_reg - SPW'(1));
    // A pop reads the memory or yields zero when the stack was empty.
    assign popped   = under_pending ? 32'h0 : rd_data;
    assign a_val    = popped;
    assign a_mag    = a_val[31] ? (~a_val + 32'd1) : a_val;
    assign b_mag    = b_reg[31] ? (~b_reg + 32'd1) : b_reg;
    assign sum      = {a_val[31], a_val} + {b_reg[31], b_reg};
    assign dif      = {a_val[31], a_val} - {b_reg[31], b_reg};
    assign umul     = a_mag * b_mag;
    assign mag48    = (state_reg == ST_MUL) ? prod_reg[63:16] : div_q;
    assign sgn49    = neg_reg ? -{1'b0, mag48} : {1'b0, mag48};
    assign div_start = (state_reg == ST_GOTA) && (req_reg == REQ_DIV);

    // Fitting pushes and arithmetic results, bar divide by zero, add one stack entry.
    assign do_push  = (req_reg <= 3'(REQ_DIV)) && !dz_reg && !over_reg;
    assign sp_after = do_push ? sp_reg + SPW'(1) : sp_reg;
    assign we       = (state_reg == ST_DONE) && out_free && do_push;
    assign waddr    = AW'(sp_reg);
    assign wdata    = res_reg;

    // Sequencer with the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            sp_reg            <= '0;
            m_tvalid          <= 1'b0;
            m_tdata           <= '0;
            under_pending_reg <= 1'b0;
            under_reg         <= 1'b0;
            over_reg          <= 1'b0;
            dz_reg            <= 1'b0;
            req_reg           <= '0;
            b_reg             <= '0;
            res_reg           <= '0;
            prod_reg          <= '0;
            neg_reg           <= 1'b0;
        end
        else
        begin
            if ((state_reg == ST_DONE) && out_free)
                m_tvalid <= 1'b1;
            else if (m_tvalid && m_tready)
                m_tvalid <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        req_reg <= s_tdata[2:0];
                        dz_reg  <= 1'b0;
                        unique case (req_t'(s_tdata[2:0]))
                            REQ_PUSH:
                            begin
                                res_reg   <= s_tdata[34:3];
                                under_reg <= 1'b0;
                                over_reg  <= (sp_reg >= SPW'(STACK_DEPTH));
                                state_reg <= ST_DONE;
                            end
                            REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV, REQ_PRINT:
                            begin
                                // Pop b: the read address already points at the top.
                                under_pending_reg <= !sp_nz;
                                if (sp_nz)
                                    sp_reg <= sp_reg - SPW'(1);
                                under_reg <= !sp_nz;
                                over_reg  <= 1'b0;
                                state_reg <= ST_RDB;
                            end
                            REQ_UNK, REQ_UNK7:
                            begin
                                under_reg <= 1'b0;
                                over_reg  <= 1'b0;
                                state_reg <= ST_DONE;
                            end
                            default:
                            begin
                                under_reg <= 1'b0;
                                over_reg  <= 1'b0;
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_RDB:
                begin
                    // rd_data now holds b (or the pop was empty).
                    b_reg <= popped;
                    if (req_reg == REQ_PRINT)
                    begin
                        res_reg   <= popped;
                        state_reg <= ST_DONE;
                    end
                    else if (req_reg == REQ_DIV && popped == 32'h0)
                    begin
                        dz_reg    <= 1'b1;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        under_pending_reg <= !sp_nz;
                        if (sp_nz)
                            sp_reg <= sp_reg - SPW'(1);
                        else
                            under_reg <= 1'b1;
                        state_reg <= ST_GOTA;
                    end
                end
                ST_GOTA:
                begin
                    // rd_data holds a (read address moved last cycle).
                    neg_reg <= a_val[31] ^ b_reg[31];
                    unique case (req_t'(req_reg))
                        REQ_ADD:
                        begin
                            res_reg   <= sat48(48'(signed'(sum)));
                            state_reg <= ST_DONE;
                        end
                        REQ_SUB:
                        begin
                            res_reg   <= sat48(48'(signed'(dif)));
                            state_reg <= ST_DONE;
                        end
                        REQ_MUL:
                        begin
                            prod_reg  <= umul;
                            state_reg <= ST_MUL;
                        end
                        default:
                        begin
                            state_reg <= ST_DIVW;
                        end
                    endcase
                end
                ST_MUL:
                begin
                    if (sgn49[48] && mag48 != 48'h0)
                        res_reg <= (mag48 > 48'h8000_0000) ? 32'h8000_0000
                                                           : sgn49[31:0];
                    else
                        res_reg <= (mag48 > 48'h7fff_ffff) ? 32'h7fff_ffff
                                                           : mag48[31:0];
                    state_reg <= ST_DONE;
                end
                ST_DIVW:
                begin
                    if (div_done)
                        state_reg <= ST_DIVF;
                end
                ST_DIVF:
                begin
                    if (sgn49[48] && mag48 != 48'h0)
                        res_reg <= (mag48 > 48'h8000_0000) ? 32'h8000_0000
                                                           : sgn49[31:0];
                    else
                        res_reg <= (mag48 > 48'h7fff_ffff) ? 32'h7fff_ffff
                                                           : mag48[31:0];
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        sp_reg    <= sp_after;
                        m_tdata   <= {3'b000,
                                      DEPTH_OUT_W'(sp_after),
                                      (req_reg == REQ_UNK) || (req_reg == REQ_UNK7),
                                      dz_reg,
                                      over_reg,
                                      under_reg,
                                      (req_reg == REQ_PRINT),
                                      (req_reg == REQ_PRINT) ? res_reg : 32'h0};
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Checks on the sequencer and stack pointer.
    `RPN_ASSERT_IMP(a_sp_range, 1'b1, sp_reg <= SPW'(STACK_DEPTH), "stack pointer past depth")
    `RPN_ASSERT_IMP(a_no_write_idle, state_reg == ST_IDLE, !we, "stack write while idle")
    `RPN_ASSERT_NXT(a_accept_busy, accept, state_reg != ST_IDLE, "accepted item left no work")
    `RPN_ASSERT_IMP(a_div_only, div_start, req_reg == REQ_DIV, "divider started off a divide")
endmodule
